/* rtl/core/tgfr_pkg.sv */
// Shared types, constants and the glyph table of the text glyph framebuffer renderer.
package tgfr_pkg;

   // Widest store address: 256 columns by 16 pages.
   localparam int MAX_ADDR_W = 12;

   localparam int GLYPH_WIDTH = 5;
   localparam logic [7:0] CURSOR_STEP = 8'd7;
   localparam logic [7:0] DEGREE_CODE = 8'hB0;

   localparam logic [1:0] ACTION_CLEAR = 2'd0;
   localparam logic [1:0] ACTION_DRAW  = 2'd1;
   localparam logic [1:0] ACTION_READ  = 2'd2;
   localparam logic [1:0] ACTION_NONE  = 2'd3;

   // Five column bytes; entry 0 is the leftmost column.
   typedef logic [GLYPH_WIDTH-1:0][7:0] glyph_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] char_code;
      logic       start_req;
      logic [7:0] start_col;
      logic [2:0] page;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       last;
   } rsp_type;

   // One decoded operation for the back end.
   typedef struct packed {
      logic [1:0]            kind;
      glyph_type             glyph;
      logic [MAX_ADDR_W-1:0] addr;
      logic [7:0]            col;
      logic                  page_ok;
      logic                  last;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_head_type;

   typedef struct packed {
      logic strobe;
      logic last;
      logic init_busy;
   } back_status_type;

   function automatic glyph_type glyph_cols(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [7:0] c2, input logic [7:0] c3,
                                            input logic [7:0] c4);
      glyph_type g;
      g[0] = c0;
      g[1] = c1;
      g[2] = c2;
      g[3] = c3;
      g[4] = c4;
      return g;
   endfunction

   // Font lookup; any code outside the font gives the blank glyph.
   function automatic glyph_type glyph_lookup(input logic [7:0] code);
      glyph_type g;
      case (code)
         8'h2D:       g = glyph_cols(8'h00, 8'h00, 8'h08, 8'h00, 8'h00);
         8'h3A:       g = glyph_cols(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
         8'h2E:       g = glyph_cols(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
         8'h25:       g = glyph_cols(8'h62, 8'h64, 8'h08, 8'h13, 8'h23);
         DEGREE_CODE: g = glyph_cols(8'h06, 8'h09, 8'h09, 8'h06, 8'h00);
         8'h30:       g = glyph_cols(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
         8'h31:       g = glyph_cols(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
         8'h32:       g = glyph_cols(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
         8'h33:       g = glyph_cols(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
         8'h34:       g = glyph_cols(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
         8'h35:       g = glyph_cols(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
         8'h36:       g = glyph_cols(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
         8'h37:       g = glyph_cols(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
         8'h38:       g = glyph_cols(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
         8'h39:       g = glyph_cols(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
         8'h43:       g = glyph_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
         8'h48:       g = glyph_cols(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
         8'h4C:       g = glyph_cols(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
         8'h50:       g = glyph_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
         8'h54:       g = glyph_cols(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
         8'h61:       g = glyph_cols(8'h20, 8'h54, 8'h54, 8'h54, 8'h78);
         8'h63:       g = glyph_cols(8'h38, 8'h44, 8'h44, 8'h44, 8'h20);
         8'h68:       g = glyph_cols(8'h7F, 8'h10, 8'h08, 8'h08, 8'h70);
         8'h6C:       g = glyph_cols(8'h00, 8'h41, 8'h7F, 8'h40, 8'h00);
         8'h75:       g = glyph_cols(8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C);
         8'h78:       g = glyph_cols(8'h44, 8'h28, 8'h10, 8'h28, 8'h44);
         default:     g = glyph_cols(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      endcase
      return g;
   endfunction

endpackage

/* rtl/core/tgfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tgfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/tgfr_front.sv */
// Front end: decodes accepted requests, keeps the cursor and read pointer, builds operations.
module tgfr_front #(
   parameter int COLUMNS    = 128,
   parameter int PAGE_COUNT = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  tgfr_pkg::req_type req,
   output logic             push,
   output tgfr_pkg::op_type op
);

   localparam int STORE_SIZE = COLUMNS * PAGE_COUNT;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int AW         = tgfr_pkg::MAX_ADDR_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_SIZE - 1);
   localparam logic [4:0]        PAGE_LIMIT = 5'(PAGE_COUNT);

   logic [7:0]        cursor_col_ff,  cursor_col_in;
   logic [2:0]        cursor_page_ff, cursor_page_in;
   logic [ADDR_W-1:0] read_ptr_ff,    read_ptr_in;

   logic [7:0]        col_use;
   logic [2:0]        page_use;
   logic [ADDR_W-1:0] rp_use;
   logic [AW-1:0]     row_base;

   always_comb begin
      col_use  = req.start_req ? req.start_col : cursor_col_ff;
      page_use = req.start_req ? req.page : cursor_page_ff;
      rp_use   = req.start_req ? '0 : read_ptr_ff;
      row_base = AW'(page_use) * AW'(COLUMNS);

      push           = 1'b0;
      op             = '0;
      cursor_col_in  = cursor_col_ff;
      cursor_page_in = cursor_page_ff;
      read_ptr_in    = read_ptr_ff;

      if (accept) begin
         case (req.action)
            tgfr_pkg::ACTION_CLEAR: begin
               push    = 1'b1;
               op.kind = tgfr_pkg::ACTION_CLEAR;
            end
            tgfr_pkg::ACTION_DRAW: begin
               push           = 1'b1;
               op.kind        = tgfr_pkg::ACTION_DRAW;
               op.glyph       = tgfr_pkg::glyph_lookup(req.char_code);
               op.addr        = row_base;
               op.col         = col_use;
               op.page_ok     = {2'b00, page_use} < PAGE_LIMIT;
               cursor_col_in  = col_use + tgfr_pkg::CURSOR_STEP;
               cursor_page_in = page_use;
            end
            tgfr_pkg::ACTION_READ: begin
               push        = 1'b1;
               op.kind     = tgfr_pkg::ACTION_READ;
               op.addr     = AW'(rp_use);
               op.last     = (rp_use == LAST_ADDR);
               read_ptr_in = (rp_use == LAST_ADDR) ? '0 : rp_use + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff  <= '0;
         cursor_page_ff <= '0;
         read_ptr_ff    <= '0;
      end else begin
         cursor_col_ff  <= cursor_col_in;
         cursor_page_ff <= cursor_page_in;
         read_ptr_ff    <= read_ptr_in;
      end
   end

endmodule

/* rtl/core/tgfr_queue.sv */
// Two-entry operation queue between the front and back ends.
module tgfr_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tgfr_pkg::op_type         push_op,
   input  logic                     pop,
   output logic                     full,
   output tgfr_pkg::queue_head_type head
);

   localparam logic [1:0] DEPTH = 2'd2;

   tgfr_pkg::op_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   always_comb begin
      full       = (count_ff == DEPTH);
      head.valid = (count_ff != 2'd0);
      head.op    = entries_ff[rd_ptr_ff];
      wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("operation pushed into a full queue");

   no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != 2'd0))
      else $error("operation popped from an empty queue");

endmodule

/* rtl/core/tgfr_back.sv */
// Back end: carries out clear sweeps, glyph column writes and store reads.
module tgfr_back #(
   parameter int COLUMNS    = 128,
   parameter int STORE_SIZE = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tgfr_pkg::queue_head_type          head,
   output logic                              pop,
   output logic                              wr_en,
   output logic [$clog2(STORE_SIZE)-1:0]     wr_addr,
   output logic [7:0]                        wr_data,
   output logic                              rd_en,
   output logic [$clog2(STORE_SIZE)-1:0]     rd_addr,
   output tgfr_pkg::back_status_type         status
);

   localparam int ADDR_W = $clog2(STORE_SIZE);
   localparam int AW     = tgfr_pkg::MAX_ADDR_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);
   localparam logic [8:0]        COL_LIMIT = 9'(COLUMNS);
   localparam logic [2:0]        LAST_STEP = 3'(tgfr_pkg::GLYPH_WIDTH - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CLEAR = 2'd1;
   localparam logic [1:0] ST_DRAW  = 2'd2;

   logic [1:0]          state_ff,   state_in;
   logic [ADDR_W-1:0]   clr_idx_ff, clr_idx_in;
   logic [2:0]          step_ff,    step_in;
   logic                init_ff,    init_in;
   logic                strobe_ff,  strobe_in;
   logic                last_ff,    last_in;
   tgfr_pkg::glyph_type glyph_ff,   glyph_in;
   logic [AW-1:0]       base_ff,    base_in;
   logic [7:0]          col_ff,     col_in;
   logic                page_ok_ff, page_ok_in;

   tgfr_pkg::glyph_type sel_glyph;
   logic [AW-1:0]       sel_base;
   logic [7:0]          sel_col;
   logic                sel_ok;
   logic [2:0]          sel_step;
   logic [8:0]          col_sum;
   logic                col_wr_en;
   logic [AW-1:0]       draw_addr;

   always_comb begin
      // The first column is written straight from the queue head.
      if (state_ff == ST_DRAW) begin
         sel_glyph = glyph_ff;
         sel_base  = base_ff;
         sel_col   = col_ff;
         sel_ok    = page_ok_ff;
         sel_step  = step_ff;
      end else begin
         sel_glyph = head.op.glyph;
         sel_base  = head.op.addr;
         sel_col   = head.op.col;
         sel_ok    = head.op.page_ok;
         sel_step  = 3'd0;
      end
      col_sum   = {1'b0, sel_col} + {6'b000000, sel_step};
      col_wr_en = sel_ok && (col_sum < COL_LIMIT);
      draw_addr = sel_base + AW'(col_sum);

      pop        = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = draw_addr[ADDR_W-1:0];
      wr_data    = sel_glyph[sel_step];
      rd_en      = 1'b0;
      rd_addr    = head.op.addr[ADDR_W-1:0];
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      step_in    = step_ff;
      init_in    = init_ff;
      strobe_in  = 1'b0;
      last_in    = 1'b0;
      glyph_in   = glyph_ff;
      base_in    = base_ff;
      col_in     = col_ff;
      page_ok_in = page_ok_ff;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.op.kind)
                  tgfr_pkg::ACTION_CLEAR: begin
                     state_in   = ST_CLEAR;
                     clr_idx_in = '0;
                  end
                  tgfr_pkg::ACTION_DRAW: begin
                     wr_en      = col_wr_en;
                     glyph_in   = head.op.glyph;
                     base_in    = head.op.addr;
                     col_in     = head.op.col;
                     page_ok_in = head.op.page_ok;
                     step_in    = 3'd1;
                     state_in   = ST_DRAW;
                  end
                  tgfr_pkg::ACTION_READ: begin
                     rd_en     = 1'b1;
                     strobe_in = 1'b1;
                     last_in   = head.op.last;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = 8'h00;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
               init_in  = 1'b0;
            end
         end
         ST_DRAW: begin
            wr_en   = col_wr_en;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      glyph_ff   <= glyph_in;
      base_ff    <= base_in;
      col_ff     <= col_in;
      page_ok_ff <= page_ok_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
         step_ff    <= '0;
         init_ff    <= 1'b1;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
         step_ff    <= step_in;
         init_ff    <= init_in;
         strobe_ff  <= strobe_in;
      end
   end

   assign status.strobe    = strobe_ff;
   assign status.last      = last_ff;
   assign status.init_busy = init_ff;

   no_port_clash: assert property (@(posedge clock) disable iff (reset) !(wr_en && rd_en))
      else $error("store written and read in the same cycle");

   strobe_follows_read: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(rd_en))
      else $error("result strobe without a store read in the previous cycle");

   draw_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW) |-> (step_ff != 3'd0 && step_ff <= LAST_STEP))
      else $error("draw column step out of range");

   init_is_clearing: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> (state_ff == ST_CLEAR))
      else $error("start-up clearing pass left early");

endmodule

/* rtl/core/text_glyph_framebuffer_renderer.sv */
// Top level of the text glyph framebuffer renderer: front end, queue, back end and store.
// A draw occupies the back end while its column bytes go to the store, one per cycle.
// Reads stream at one transfer per cycle while busy is low; a result is strobed from the
// registered store read, and behind a queued draw or clear it waits until that work is done.
// A clear occupies the back end while it sweeps every store byte, one per cycle.
// After reset a clearing pass over every store byte holds busy high.
// Results cannot be stalled: each is presented for exactly one cycle.
module text_glyph_framebuffer_renderer #(
   parameter int COLUMNS    = 128,
   parameter int PAGE_COUNT = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tgfr_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output tgfr_pkg::rsp_type rsp_payload
);

   // The store holds PAGE_COUNT pages of COLUMNS bytes, addressed page * COLUMNS + column.
   localparam int STORE_SIZE = COLUMNS * PAGE_COUNT;
   localparam int ADDR_W     = $clog2(STORE_SIZE);

   logic                     accept;
   logic                     push;
   tgfr_pkg::op_type         push_op;
   logic                     pop;
   logic                     queue_full;
   tgfr_pkg::queue_head_type head;
   tgfr_pkg::back_status_type status;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   // A request transfer is taken whenever the queue has room and the start-up
   // clearing pass is over; the back end drains the queue at its own pace.
   assign busy   = queue_full || status.init_busy;
   assign accept = start && !busy;

   // The front end keeps the cursor and read pointer, so these update at the
   // moment of the transfer, independent of when the back end acts on them.
   tgfr_front #(
      .COLUMNS    (COLUMNS),
      .PAGE_COUNT (PAGE_COUNT)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .push   (push),
      .op     (push_op)
   );

   tgfr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .full    (queue_full),
      .head    (head)
   );

   // Operations are carried out strictly in order, so a read always sees
   // every earlier clear and draw.
   tgfr_back #(
      .COLUMNS    (COLUMNS),
      .STORE_SIZE (STORE_SIZE)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .status  (status)
   );

   tgfr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The registered read data and the registered strobe line up in the same cycle.
   assign rsp_strobe             = status.strobe;
   assign rsp_payload.pixel_byte = rd_data;
   assign rsp_payload.last       = status.last;

endmodule

/* dv/tgfr_shadow_pkg.sv */
// Shadow framebuffer, font table and result checking for the renderer testbench.
`timescale 1ns / 100ps

package tgfr_shadow_pkg;

   localparam int SHADOW_COLUMNS = 128;
   localparam int SHADOW_PAGES   = 8;
   localparam int STORE_BYTES    = SHADOW_COLUMNS * SHADOW_PAGES;
   localparam int GLYPH_TOTAL    = 27;
   localparam int REPORT_LIMIT   = 10;

   // Character codes of the font, first entry in the top byte.
   localparam logic [GLYPH_TOTAL*8-1:0] FONT_CODES = {
      8'h20, 8'h2D, 8'h3A, 8'h2E, 8'h25, 8'hB0, 8'h30, 8'h31, 8'h32,
      8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h43, 8'h48,
      8'h4C, 8'h50, 8'h54, 8'h61, 8'h63, 8'h68, 8'h6C, 8'h75, 8'h78
   };

   // Five column bytes per glyph, leftmost column in the top byte of each entry.
   localparam logic [GLYPH_TOTAL*40-1:0] FONT_GLYPHS = {
      40'h0000000000, 40'h0000080000, 40'h0036360000, 40'h0060600000,
      40'h6264081323, 40'h0609090600, 40'h3E5149453E, 40'h00427F4000,
      40'h4261514946, 40'h2141454B31, 40'h1814127F10, 40'h2745454539,
      40'h3C4A494930, 40'h0171090503, 40'h3649494936, 40'h064949291E,
      40'h3E41414122, 40'h7F0808087F, 40'h7F40404040, 40'h7F09090906,
      40'h01017F0101, 40'h2054545478, 40'h3844444420, 40'h7F10080870,
      40'h00417F4000, 40'h3C4040207C, 40'h4428102844
   };

   function automatic logic [7:0] font_code_at(input int index);
      return FONT_CODES[(GLYPH_TOTAL-1-index)*8 +: 8];
   endfunction

   // Codes outside the font fall back to the blank glyph.
   function automatic logic [39:0] font_columns(input logic [7:0] code);
      int k;
      font_columns = '0;
      for (k = 0; k < GLYPH_TOTAL; k++)
         if (font_code_at(k) == code)
            font_columns = FONT_GLYPHS[(GLYPH_TOTAL-1-k)*40 +: 40];
   endfunction

   class framebuffer_shadow;
      logic [7:0]           frame_bytes [STORE_BYTES];
      logic [7:0]           cursor_col;
      logic [2:0]           cursor_page;
      int unsigned          read_ptr;
      tgfr_pkg::rsp_type    bytes_due [$];
      int unsigned          bytes_seen;
      int unsigned          mismatches;

      function new();
         foreach (frame_bytes[i])
            frame_bytes[i] = 8'h00;
         cursor_col  = '0;
         cursor_page = '0;
         read_ptr    = 0;
         bytes_seen  = 0;
         mismatches  = 0;
      endfunction

      function void flag(input string what);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%s", what);
      endfunction

      // Applies one accepted request to the shadow state.
      function void apply_request(input tgfr_pkg::req_type item);
         logic [39:0] glyph;
         int unsigned column;
         int i;
         tgfr_pkg::rsp_type due;
         case (item.action)
            tgfr_pkg::ACTION_CLEAR: begin
               foreach (frame_bytes[j])
                  frame_bytes[j] = 8'h00;
            end
            tgfr_pkg::ACTION_DRAW: begin
               glyph = font_columns(item.char_code);
               if (item.start_req) begin
                  cursor_col  = item.start_col;
                  cursor_page = item.page;
               end
               if (cursor_page < SHADOW_PAGES) begin
                  for (i = 0; i < tgfr_pkg::GLYPH_WIDTH; i++) begin
                     column = cursor_col + i;
                     if (column < SHADOW_COLUMNS)
                        frame_bytes[cursor_page*SHADOW_COLUMNS + column] = glyph[39-8*i -: 8];
                  end
               end
               cursor_col = cursor_col + tgfr_pkg::CURSOR_STEP;
            end
            tgfr_pkg::ACTION_READ: begin
               if (item.start_req || read_ptr >= STORE_BYTES)
                  read_ptr = 0;
               due.pixel_byte = frame_bytes[read_ptr];
               due.last       = (read_ptr == STORE_BYTES - 1);
               bytes_due.push_back(due);
               read_ptr = (read_ptr + 1) % STORE_BYTES;
            end
            default: ;
         endcase
      endfunction

      function void compare_byte(input tgfr_pkg::rsp_type seen);
         tgfr_pkg::rsp_type due;
         bytes_seen++;
         if (bytes_due.size() == 0) begin
            flag($sformatf("result %0d unexpected: pixel_byte %02h last %0d",
                           bytes_seen, seen.pixel_byte, seen.last));
            return;
         end
         due = bytes_due.pop_front();
         if (seen.pixel_byte !== due.pixel_byte || seen.last !== due.last)
            flag($sformatf("result %0d wrong: pixel_byte exp %02h got %02h, last exp %0d got %0d",
                           bytes_seen, due.pixel_byte, seen.pixel_byte, due.last, seen.last));
      endfunction
   endclass

endpackage

/* dv/tb_text_glyph_framebuffer_renderer.sv */
// Testbench for the text glyph framebuffer renderer: random draws, clears and frame reads.
`timescale 1ns / 100ps

module tb_text_glyph_framebuffer_renderer;

   // Request transfers for the whole run, the closing frame sweep included.
   localparam int ITEM_BUDGET    = 1100;
   // A clear keeps the back end occupied while it sweeps the whole store, so busy
   // can stay high that long, and so does the clearing pass after reset; the watchdog
   // allows several times the longest quiet spell.
   localparam int WATCHDOG_LIMIT = 8000;
   // Read results strobe from the registered store read; spare cycles at the end catch strays.
   localparam int TAIL_CYCLES    = 8;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   tgfr_pkg::req_type req_payload = '0;
   logic              rsp_strobe;
   tgfr_pkg::rsp_type rsp_payload;

   tgfr_shadow_pkg::framebuffer_shadow board = new();
   int unsigned       idle_cycles = 0;
   int unsigned       quiet_items = 0;
   int unsigned       items_sent  = 0;

   text_glyph_framebuffer_renderer #(
      .COLUMNS    (tgfr_shadow_pkg::SHADOW_COLUMNS),
      .PAGE_COUNT (tgfr_shadow_pkg::SHADOW_PAGES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Both channels are sampled at the rising edge, so the values seen are those that
   // held during the cycle that the edge closes. A request transfer is noted in the
   // shadow before any result of the same edge is compared; read results always lag
   // their transfer, so the order within the edge does not matter for the queue.
   // The watchdog counts edges at which neither channel moved anything.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (start && !busy)
            board.apply_request(req_payload);
         if (rsp_strobe)
            board.compare_byte(rsp_payload);
         if ((start && !busy) || rsp_strobe) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Mostly back-to-back or short gaps, now and then a long one, and occasional
   // stretches of items with no gap at all so that the block sees full rate.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_items != 0) begin
         quiet_items--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         quiet_items = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55)
         return 0;
      if (roll < 87)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic tgfr_pkg::req_type make_req(input logic [1:0] action,
                                                  input logic [7:0] code,
                                                  input logic start_req,
                                                  input logic [7:0] col,
                                                  input logic [2:0] page);
      tgfr_pkg::req_type item;
      item.action    = action;
      item.char_code = code;
      item.start_req = start_req;
      item.start_col = col;
      item.page      = page;
      return item;
   endfunction

   // Mostly characters from the font, the degree sign among them, else any code.
   function automatic logic [7:0] pick_code();
      if ($urandom_range(0, 99) < 70)
         return tgfr_shadow_pkg::font_code_at($urandom_range(0,
                                              tgfr_shadow_pkg::GLYPH_TOTAL - 1));
      return 8'($urandom_range(0, 255));
   endfunction

   // String starts lean towards the right edge, where glyphs get clipped and the
   // cursor wraps round.
   function automatic logic [7:0] pick_start_col();
      if ($urandom_range(0, 99) < 35)
         return 8'($urandom_range(118, 255));
      return 8'($urandom_range(0, 127));
   endfunction

   // Called at a rising edge. The payload is presented, start raised, and the task
   // returns at the edge at which the block takes the transfer. Start is written once
   // per step: lowered only when a gap is to follow.
   task automatic issue(input tgfr_pkg::req_type item);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic draw_char(input logic [7:0] code, input logic start_req,
                            input logic [7:0] col, input logic [2:0] page);
      issue(make_req(tgfr_pkg::ACTION_DRAW, code, start_req, col, page));
   endtask

   task automatic read_byte(input logic start_req);
      issue(make_req(tgfr_pkg::ACTION_READ, 8'($urandom), start_req, 8'($urandom),
                     3'($urandom)));
   endtask

   // Reads the whole frame from byte 0, plus one more to see the pointer wrap.
   task automatic sweep_frame();
      int k;
      read_byte(1'b1);
      for (k = 0; k < tgfr_shadow_pkg::STORE_BYTES; k++)
         read_byte(1'b0);
   endtask

   initial begin
      int unsigned choice;
      int unsigned burst;
      int          k;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first read checks that the store came out of reset clear.
      read_byte(1'b1);
      // A clear must wipe the character just drawn.
      draw_char(8'h30, 1'b1, 8'd0, 3'd0);
      issue(make_req(tgfr_pkg::ACTION_CLEAR, 8'hFF, 1'b1, 8'hFF, 3'd7));
      read_byte(1'b1);
      read_byte(1'b0);
      draw_char(8'h30, 1'b1, 8'd0, 3'd0);
      draw_char(tgfr_pkg::DEGREE_CODE, 1'b0, 8'hFF, 3'd7);
      draw_char(8'h48, 1'b0, 8'd0, 3'd0);
      // Unknown codes draw blank columns over the letter just written.
      draw_char(8'hFF, 1'b1, 8'd14, 3'd0);
      draw_char(8'h00, 1'b0, 8'd0, 3'd0);
      // A glyph straddling the right edge loses its last column.
      draw_char(8'h25, 1'b1, 8'd124, 3'd0);
      // Entirely past the edge: nothing written, the cursor wraps from 255 to 6.
      draw_char(8'h48, 1'b1, 8'd255, 3'd7);
      draw_char(8'h37, 1'b0, 8'd0, 3'd0);
      draw_char(8'h78, 1'b1, 8'd127, 3'd7);
      // The unused action code must leave everything alone.
      issue(make_req(tgfr_pkg::ACTION_NONE, 8'hFF, 1'b1, 8'hFF, 3'd7));
      read_byte(1'b0);
      read_byte(1'b1);
      for (k = 0; k < 8; k++)
         read_byte(1'b0);

      // Random part: mostly text strings and read bursts with random content, with
      // single draws, clears and ignored codes mixed in. Room is left for the
      // closing sweep of the whole frame.
      while (items_sent + tgfr_shadow_pkg::STORE_BYTES + 1 < ITEM_BUDGET) begin
         choice = $urandom_range(0, 99);
         if (choice < 45) begin
            burst = $urandom_range(1, 10);
            draw_char(pick_code(), 1'b1, pick_start_col(), 3'($urandom_range(0, 7)));
            repeat (burst)
               draw_char(pick_code(), $urandom_range(0, 99) < 5, 8'($urandom),
                         3'($urandom));
         end else if (choice < 80) begin
            burst = $urandom_range(1, 40);
            read_byte($urandom_range(0, 99) < 15);
            repeat (burst - 1)
               read_byte($urandom_range(0, 99) < 3);
         end else if (choice < 90) begin
            draw_char(8'($urandom), 1'($urandom), 8'($urandom), 3'($urandom));
         end else if (choice < 95) begin
            issue(make_req(tgfr_pkg::ACTION_NONE, 8'($urandom), 1'($urandom), 8'($urandom),
                           3'($urandom)));
         end else if (choice < 97) begin
            issue(make_req(tgfr_pkg::ACTION_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom),
                           3'($urandom)));
         end else begin
            read_byte(1'($urandom));
         end
      end
      // Whole frame, covering every byte written, the last-byte flag and the wrap.
      sweep_frame();

      // Drain: the watchdog ends the run if a result never turns up.
      start <= 1'b0;
      while (board.bytes_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.bytes_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
